>>> hdl/dkw_pkg.sv
package dkw_pkg;

   typedef enum logic [1:0] {
      KERNEL_BISQUARE    = 2'd0,
      KERNEL_GAUSSIAN    = 2'd1,
      KERNEL_TRICUBE     = 2'd2,
      KERNEL_EXPONENTIAL = 2'd3
   } kernel_mode_type;

   // CSR indexes
   localparam logic CSR_KERNEL_MODE     = 1'b0;
   localparam logic CSR_BANDWIDTH_RECIP = 1'b1;

   localparam logic [31:0] BANDWIDTH_RECIP_RESET = 32'd65536;

   // ln 2 in Q0.32
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   // k estimate: floor(((x >> 16) * K_RECIP) >> K_RECIP_SHIFT), low by at most one
   localparam logic [8:0]  K_RECIP       = 9'd369;
   localparam int unsigned K_RECIP_SHIFT = 24;

   localparam int unsigned EXP_TERMS      = 14;
   localparam int unsigned TERM_DIV_SHIFT = 34;

   localparam int unsigned REDUCE_STAGES    = 4;
   localparam int unsigned TERM_STAGES      = 3;
   localparam int unsigned ROUND_STAGES     = 2;
   localparam int unsigned EXP_LATENCY      = REDUCE_STAGES + (EXP_TERMS - 1) * TERM_STAGES
                                              + ROUND_STAGES;
   localparam int unsigned POLY_CORE_STAGES = 5;

   // One slot of the exp series pipeline
   typedef struct packed {
      logic            valid;
      kernel_mode_type mode;
      logic            zero;
      logic [5:0]      k;
      logic [31:0]     r;
      logic [31:0]     term;
      logic [32:0]     acc;
   } exp_stage_type;

endpackage

>>> hdl/dkw_poly.sv
module dkw_poly
   import dkw_pkg::*;
#(
   parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [63:0]               in_u,
   input  kernel_mode_type           in_mode,
   output logic [WEIGHT_FRAC_BITS:0] out_weight
);

   localparam logic [31:0] Q31_ONE     = 32'h8000_0000;
   localparam int unsigned ROUND_SHIFT = 31 - WEIGHT_FRAC_BITS;
   localparam logic [32:0] ROUND_HALF  = 33'd1 << (ROUND_SHIFT - 1);
   localparam int unsigned DELAY       = EXP_LATENCY - POLY_CORE_STAGES;

   // P1: t = u >> 1, t^2
   logic        p1_oob_in;
   logic [63:0] p1_tt_in;
   logic        p1_oob_ff;
   logic        p1_cube_ff;
   logic [31:0] p1_t_ff;
   logic [63:0] p1_tt_ff;

   // P2: p = t^2 (bisquare) or t^3 (tricube)
   logic [31:0] p2_mult;
   logic [63:0] p2_pm_in;
   logic [63:0] p2_pm_ff;
   logic        p2_oob_ff;
   logic        p2_cube_ff;

   // P3: a = 1 - p, a^2
   logic [31:0] p3_a_in;
   logic [63:0] p3_aa_in;
   logic [31:0] p3_a_ff;
   logic [63:0] p3_aa_ff;
   logic        p3_oob_ff;
   logic        p3_cube_ff;

   // P4: w = a^2 or a^3
   logic [31:0] p4_mult;
   logic [63:0] p4_wm_in;
   logic [63:0] p4_wm_ff;
   logic        p4_oob_ff;

   // P5: round to output format
   logic [32:0]               p5_round;
   logic [WEIGHT_FRAC_BITS:0] p5_weight_in;
   logic [WEIGHT_FRAC_BITS:0] p5_weight_ff;

   logic [WEIGHT_FRAC_BITS:0] delay_ff [DELAY];

   // outside support when u > 1.0
   assign p1_oob_in = (in_u[63:33] != '0) || (in_u[32] && (in_u[31:0] != '0));
   assign p1_tt_in  = 64'(in_u[32:1]) * 64'(in_u[32:1]);

   assign p2_mult  = p1_cube_ff ? p1_t_ff : Q31_ONE;
   assign p2_pm_in = 64'(p1_tt_ff[62:31]) * 64'(p2_mult);

   assign p3_a_in  = Q31_ONE - p2_pm_ff[62:31];
   assign p3_aa_in = 64'(p3_a_in) * 64'(p3_a_in);

   assign p4_mult  = p3_cube_ff ? p3_a_ff : Q31_ONE;
   assign p4_wm_in = 64'(p3_aa_ff[62:31]) * 64'(p4_mult);

   assign p5_round     = 33'(p4_wm_ff[62:31]) + ROUND_HALF;
   assign p5_weight_in = p4_oob_ff ? '0 : (WEIGHT_FRAC_BITS + 1)'(p5_round >> ROUND_SHIFT);

   always_ff @(posedge clock) begin
      if (enable) begin
         p1_oob_ff    <= p1_oob_in;
         p1_cube_ff   <= (in_mode == KERNEL_TRICUBE);
         p1_t_ff      <= in_u[32:1];
         p1_tt_ff     <= p1_tt_in;
         p2_pm_ff     <= p2_pm_in;
         p2_oob_ff    <= p1_oob_ff;
         p2_cube_ff   <= p1_cube_ff;
         p3_a_ff      <= p3_a_in;
         p3_aa_ff     <= p3_aa_in;
         p3_oob_ff    <= p2_oob_ff;
         p3_cube_ff   <= p2_cube_ff;
         p4_wm_ff     <= p4_wm_in;
         p4_oob_ff    <= p3_oob_ff;
         p5_weight_ff <= p5_weight_in;
         delay_ff[0]  <= p5_weight_ff;
         for (int i = 1; i < DELAY; i++) begin
            delay_ff[i] <= delay_ff[i - 1];
         end
      end
   end

   // aligned with the exp lane
   assign out_weight = delay_ff[DELAY - 1];

endmodule

>>> hdl/dkw_term.sv
module dkw_term
   import dkw_pkg::*;
#(
   parameter int unsigned TERM_N = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  exp_stage_type stage_in,
   output exp_stage_type stage_out
);

   localparam logic [TERM_DIV_SHIFT-1:0] DIV_RECIP =
      TERM_DIV_SHIFT'((64'd1 << TERM_DIV_SHIFT) / TERM_N);
   localparam logic TERM_ODD = ((TERM_N % 2) == 1);

   exp_stage_type a_ff;
   logic [63:0]   a_prod_in;
   logic [63:0]   a_prod_ff;

   exp_stage_type                b_ff;
   logic [TERM_DIV_SHIFT+31:0]   b_qm;
   logic [31:0]                  b_v_ff;
   logic [31:0]                  b_q0_ff;

   logic [35:0]   c_qn;
   logic [35:0]   c_rem;
   logic          c_carry;
   logic [31:0]   c_q;
   exp_stage_type c_in;
   exp_stage_type c_ff;

   // term * r
   assign a_prod_in = 64'(stage_in.term) * 64'(stage_in.r);

   // quotient estimate by reciprocal, low by at most one
   assign b_qm = (TERM_DIV_SHIFT + 32)'(a_prod_ff[63:32]) * (TERM_DIV_SHIFT + 32)'(DIV_RECIP);

   assign c_qn    = 36'(b_q0_ff) * 36'(TERM_N);
   assign c_rem   = 36'(b_v_ff) - c_qn;
   assign c_carry = (c_rem >= 36'(TERM_N));
   assign c_q     = b_q0_ff + 32'(c_carry);

   always_comb begin
      c_in      = b_ff;
      c_in.term = c_q;
      if (TERM_ODD) begin
         c_in.acc = b_ff.acc - 33'(c_q);
      end else begin
         c_in.acc = b_ff.acc + 33'(c_q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
         c_ff.valid <= 1'b0;
      end else if (enable) begin
         a_ff <= stage_in;
         b_ff <= a_ff;
         c_ff <= c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_prod_ff <= a_prod_in;
         b_v_ff    <= a_prod_ff[63:32];
         b_q0_ff   <= b_qm[TERM_DIV_SHIFT +: 32];
      end
   end

   assign stage_out = c_ff;

endmodule

>>> hdl/dkw_exp.sv
module dkw_exp
   import dkw_pkg::*;
#(
   parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      in_valid,
   input  kernel_mode_type           in_mode,
   input  logic [63:0]               in_u,
   output logic                      out_valid,
   output kernel_mode_type           out_mode,
   output logic [WEIGHT_FRAC_BITS:0] out_weight
);

   localparam logic [32:0] ACC_ONE     = 33'h1_0000_0000;
   localparam logic [6:0]  SHIFT_BASE  = 7'(32 - WEIGHT_FRAC_BITS);
   localparam logic [6:0]  SHIFT_LIMIT = 7'd63;

   // E1: Gaussian square, underflow check on u
   logic            e1_zero_in;
   logic [63:0]     e1_sq_in;
   logic            e1_valid_ff;
   kernel_mode_type e1_mode_ff;
   logic            e1_zero_ff;
   logic [36:0]     e1_u_ff;
   logic [63:0]     e1_sq_ff;

   // E2: argument select, k estimate
   logic [36:0]     e2_x_in;
   logic            e2_zero_in;
   logic [29:0]     e2_kq_in;
   logic            e2_valid_ff;
   kernel_mode_type e2_mode_ff;
   logic            e2_zero_ff;
   logic [36:0]     e2_x_ff;
   logic [29:0]     e2_kq_ff;

   // E3: k * ln2
   logic [5:0]      e3_k0_in;
   logic [37:0]     e3_kl_in;
   logic            e3_valid_ff;
   kernel_mode_type e3_mode_ff;
   logic            e3_zero_ff;
   logic [36:0]     e3_x_ff;
   logic [5:0]      e3_k0_ff;
   logic [37:0]     e3_kl_ff;

   // E4: remainder and one correction step
   logic [38:0]     e4_d1;
   logic [38:0]     e4_d2;
   exp_stage_type   e4_in;
   exp_stage_type   e4_ff;

   exp_stage_type   chain [EXP_TERMS];

   // R1/R2: final scale by 2^-k with rounding
   logic [6:0]                r1_sh_in;
   logic [63:0]               r1_sum_in;
   logic                      r1_zero_in;
   logic                      r1_valid_ff;
   kernel_mode_type           r1_mode_ff;
   logic                      r1_zero_ff;
   logic [6:0]                r1_sh_ff;
   logic [63:0]               r1_sum_ff;
   logic [WEIGHT_FRAC_BITS:0] r2_weight_in;
   logic                      r2_valid_ff;
   kernel_mode_type           r2_mode_ff;
   logic [WEIGHT_FRAC_BITS:0] r2_weight_ff;

   assign e1_sq_in   = 64'(in_u[35:4]) * 64'(in_u[35:4]);
   assign e1_zero_in = (in_mode == KERNEL_GAUSSIAN) ? (in_u[63:35] != '0)
                                                    : (in_u[63:37] != '0);

   always_comb begin
      if (e1_mode_ff == KERNEL_GAUSSIAN) begin
         e2_x_in    = e1_sq_ff[60:24];
         e2_zero_in = e1_zero_ff || (e1_sq_ff[63:61] != '0);
      end else begin
         e2_x_in    = e1_u_ff;
         e2_zero_in = e1_zero_ff;
      end
   end

   assign e2_kq_in = 30'(e2_x_in[36:16]) * 30'(K_RECIP);

   assign e3_k0_in = e2_kq_ff[K_RECIP_SHIFT +: 6];
   assign e3_kl_in = 38'(e3_k0_in) * 38'(LN2_Q32);

   assign e4_d1 = 39'(e3_x_ff) - 39'(e3_kl_ff);
   assign e4_d2 = e4_d1 - 39'(LN2_Q32);

   always_comb begin
      e4_in.valid = e3_valid_ff;
      e4_in.mode  = e3_mode_ff;
      e4_in.zero  = e3_zero_ff;
      if (!e4_d2[38]) begin
         e4_in.k = e3_k0_ff + 6'd1;
         e4_in.r = e4_d2[31:0];
      end else begin
         e4_in.k = e3_k0_ff;
         e4_in.r = e4_d1[31:0];
      end
      // first series term folded in here
      e4_in.term = e4_in.r;
      e4_in.acc  = ACC_ONE - 33'(e4_in.r);
   end

   assign chain[0] = e4_ff;

   for (genvar n = 2; n <= EXP_TERMS; n++) begin : g_term
      dkw_term #(
         .TERM_N (n)
      ) u_term (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .stage_in  (chain[n - 2]),
         .stage_out (chain[n - 1])
      );
   end

   assign r1_sh_in   = SHIFT_BASE + 7'(chain[EXP_TERMS-1].k);
   assign r1_sum_in  = 64'(chain[EXP_TERMS-1].acc) + (64'd1 << (r1_sh_in - 7'd1));
   assign r1_zero_in = chain[EXP_TERMS-1].zero || (r1_sh_in >= SHIFT_LIMIT);

   assign r2_weight_in = r1_zero_ff ? '0 : (WEIGHT_FRAC_BITS + 1)'(r1_sum_ff >> r1_sh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
         e2_valid_ff <= 1'b0;
         e3_valid_ff <= 1'b0;
         e4_ff.valid <= 1'b0;
         r1_valid_ff <= 1'b0;
         r2_valid_ff <= 1'b0;
      end else if (enable) begin
         e1_valid_ff <= in_valid;
         e2_valid_ff <= e1_valid_ff;
         e3_valid_ff <= e2_valid_ff;
         e4_ff       <= e4_in;
         r1_valid_ff <= chain[EXP_TERMS-1].valid;
         r2_valid_ff <= r1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         e1_mode_ff   <= in_mode;
         e1_zero_ff   <= e1_zero_in;
         e1_u_ff      <= in_u[36:0];
         e1_sq_ff     <= e1_sq_in;
         e2_mode_ff   <= e1_mode_ff;
         e2_zero_ff   <= e2_zero_in;
         e2_x_ff      <= e2_x_in;
         e2_kq_ff     <= e2_kq_in;
         e3_mode_ff   <= e2_mode_ff;
         e3_zero_ff   <= e2_zero_ff;
         e3_x_ff      <= e2_x_ff;
         e3_k0_ff     <= e3_k0_in;
         e3_kl_ff     <= e3_kl_in;
         r1_mode_ff   <= chain[EXP_TERMS-1].mode;
         r1_zero_ff   <= r1_zero_in;
         r1_sh_ff     <= r1_sh_in;
         r1_sum_ff    <= r1_sum_in;
         r2_mode_ff   <= r1_mode_ff;
         r2_weight_ff <= r2_weight_in;
      end
   end

   assign out_valid  = r2_valid_ff;
   assign out_mode   = r2_mode_ff;
   assign out_weight = r2_weight_ff;

endmodule

>>> hdl/distance_kernel_weight.sv
// Distance kernel weight: one unsigned Q16.16 distance in, one Q1.F weight out
// (F = WEIGHT_FRAC_BITS, 1 << F means 1.0).
// Channels: req_* carries distances in, rsp_* carries weights out; a transaction
// completes on a rising edge with valid high and stall low. csr_* writes the
// kernel mode (index 0) and the reciprocal bandwidth (index 1, Q16.16); write
// only while no transaction is in flight.
// Throughput: one transaction per cycle, sustained while rsp_stall stays low.
// Pipeline: after the accepting edge a weight passes the input register,
// the distance * bandwidth multiply, 4 range-reduction stages, 13 series terms
// of 3 stages each (multiply, reciprocal divide, correct and accumulate),
// 2 rounding stages and the output register, where rsp_valid rises. Bisquare
// and tricube are computed in a short side lane, delayed to match the exp lane.
// Reset: mode bisquare, reciprocal bandwidth 1.0, pipeline and output empty.
// Receiver stall: the output register holds; one more weight lands in a skid
// register, after which req_stall goes high and the whole pipeline freezes.
// Nothing is lost or repeated.
module distance_kernel_weight
   import dkw_pkg::*;
#(
   parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [31:0]               req_distance,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [WEIGHT_FRAC_BITS:0] rsp_weight,
   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic [31:0]               csr_write_data
);

   // configuration
   kernel_mode_type mode_ff;
   logic [31:0]     recip_ff;

   // global advance: frozen only while the skid register is full
   logic pipe_en;

   // S0: input register
   logic            s0_valid_ff;
   kernel_mode_type s0_mode_ff;
   logic [31:0]     s0_distance_ff;

   // S1: u = distance * reciprocal bandwidth, Q32.32
   logic [63:0]     s1_u_in;
   logic            s1_valid_ff;
   kernel_mode_type s1_mode_ff;
   logic [63:0]     s1_u_ff;

   // lane outputs, aligned
   logic                      exp_valid;
   kernel_mode_type           exp_mode;
   logic [WEIGHT_FRAC_BITS:0] exp_weight;
   logic [WEIGHT_FRAC_BITS:0] poly_weight;
   logic                      res_fire;
   logic [WEIGHT_FRAC_BITS:0] res_weight;

   // output register and skid
   logic                      out_take;
   logic                      out_valid_ff;
   logic [WEIGHT_FRAC_BITS:0] out_weight_ff;
   logic                      skid_valid_ff;
   logic [WEIGHT_FRAC_BITS:0] skid_weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= KERNEL_BISQUARE;
         recip_ff <= BANDWIDTH_RECIP_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KERNEL_MODE:     mode_ff  <= kernel_mode_type'(csr_write_data[1:0]);
            CSR_BANDWIDTH_RECIP: recip_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign pipe_en   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   assign s1_u_in = 64'(s0_distance_ff) * 64'(recip_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         // req_stall is low here, so req_valid means accepted
         s0_valid_ff <= req_valid;
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s0_mode_ff     <= mode_ff;
         s0_distance_ff <= req_distance;
         s1_mode_ff     <= s0_mode_ff;
         s1_u_ff        <= s1_u_in;
      end
   end

   // Gaussian and exponential lane; also carries valid and mode
   dkw_exp #(
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_dkw_exp (
      .clock      (clock),
      .reset      (reset),
      .enable     (pipe_en),
      .in_valid   (s1_valid_ff),
      .in_mode    (s1_mode_ff),
      .in_u       (s1_u_ff),
      .out_valid  (exp_valid),
      .out_mode   (exp_mode),
      .out_weight (exp_weight)
   );

   // bisquare and tricube lane
   dkw_poly #(
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_dkw_poly (
      .clock      (clock),
      .enable     (pipe_en),
      .in_u       (s1_u_ff),
      .in_mode    (s1_mode_ff),
      .out_weight (poly_weight)
   );

   assign res_fire   = exp_valid && pipe_en;
   assign res_weight = ((exp_mode == KERNEL_GAUSSIAN) || (exp_mode == KERNEL_EXPONENTIAL))
                       ? exp_weight : poly_weight;

   assign out_take = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_take) begin
         if (skid_valid_ff) begin
            // pipeline is frozen this cycle, drain the skid
            out_valid_ff  <= 1'b1;
            out_weight_ff <= skid_weight_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= res_fire;
            out_weight_ff <= res_weight;
         end
      end else if (res_fire) begin
         // output held, catch the one weight that left the pipeline
         skid_valid_ff  <= 1'b1;
         skid_weight_ff <= res_weight;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_weight = out_weight_ff;

endmodule

>>> hdl/dkw_checker.sv
module dkw_checker #(
   parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [WEIGHT_FRAC_BITS:0] rsp_weight
);

   localparam logic [WEIGHT_FRAC_BITS:0] WEIGHT_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output or stall not clear after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_weight))
      else $error("stalled response changed");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_weight <= WEIGHT_ONE)
      else $error("weight above one");

   a_stall_needs_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty output");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("request stall without a stalled response");

endmodule

bind distance_kernel_weight dkw_checker #(
   .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
) u_dkw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_weight (rsp_weight)
);
